@@ rtl/core/rti_pkg.sv @@
// ----------------------------------------------------------------------------
// rti_pkg
// Shared types, register indexes and fixed-point helpers for the ray/triangle
// intersection pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package rti_pkg;

    localparam int SAT_W = 68;

    typedef logic signed [31:0] t_q;
    typedef logic signed [63:0] t_prod;

    typedef struct packed {
        t_q x;
        t_q y;
        t_q z;
    } t_vec;

    typedef struct packed {
        t_vec v0;
        t_vec v1;
        t_vec v2;
    } t_tri;

    typedef struct packed {
        t_q vertex0_x;
        t_q vertex0_y;
        t_q vertex0_z;
        t_q vertex1_x;
        t_q vertex1_y;
        t_q vertex1_z;
        t_q vertex2_x;
        t_q vertex2_y;
        t_q vertex2_z;
    } t_tri_in;

    typedef struct packed {
        logic hit;
        t_q   distance;
    } t_res;

    typedef struct packed {
        t_vec        org;
        t_vec        dir;
        logic [15:0] eps;
    } t_ray;

    typedef struct packed {
        t_tri              vtx;
        t_vec              n;
        logic signed [32:0] num;
        t_q                den;
        logic              ok;
    } t_geom;

    typedef struct packed {
        t_tri vtx;
        t_vec n;
        t_q   t;
        logic ok;
    } t_tval;

    typedef enum logic [2:0] {
        CFG_ORG_X = 3'd0,
        CFG_ORG_Y = 3'd1,
        CFG_ORG_Z = 3'd2,
        CFG_DIR_X = 3'd3,
        CFG_DIR_Y = 3'd4,
        CFG_DIR_Z = 3'd5,
        CFG_EPS   = 3'd6
    } t_cfg_idx;

    localparam t_q Q_MAX = 32'sh7FFFFFFF;
    localparam t_q Q_MIN = 32'sh80000000;

    function automatic t_q sat_q(input logic signed [SAT_W-1:0] v);
        if (v[SAT_W-1:31] == '0 || v[SAT_W-1:31] == '1) begin
            return v[31:0];
        end
        return v[SAT_W-1] ? Q_MIN : Q_MAX;
    endfunction

    function automatic t_q sub_q(input t_q a, input t_q b);
        return sat_q(SAT_W'(a) - SAT_W'(b));
    endfunction

    function automatic t_vec vsub(input t_vec a, input t_vec b);
        t_vec r;
        r.x = sub_q(a.x, b.x);
        r.y = sub_q(a.y, b.y);
        r.z = sub_q(a.z, b.z);
        return r;
    endfunction

    function automatic t_prod mul_q(input t_q a, input t_q b);
        return 64'(a) * 64'(b);
    endfunction

    function automatic t_q cross_c(input t_prod pa, input t_prod pb, input int sh);
        logic signed [64:0] d;
        d = 65'(pa) - 65'(pb);
        return sat_q(SAT_W'(d >>> sh));
    endfunction

    function automatic t_q dot3(input t_prod p0, input t_prod p1, input t_prod p2,
                                input int sh);
        return sat_q(SAT_W'(p0 >>> sh) + SAT_W'(p1 >>> sh) + SAT_W'(p2 >>> sh));
    endfunction

endpackage

`default_nettype wire

@@ rtl/core/rti_stream_if.sv @@
// ----------------------------------------------------------------------------
// rti_stream_if
// Valid/ready channel carrying one payload per transaction.
// ----------------------------------------------------------------------------
`default_nettype none

interface rti_stream_if #(
    parameter type t_data = logic
) ();
    logic  valid;
    logic  ready;
    t_data data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

@@ rtl/core/rti_setup.sv @@
// ----------------------------------------------------------------------------
// rti_setup
// Edge vectors, plane normal, plane dot products and parallel rejection.
// ----------------------------------------------------------------------------
`default_nettype none

module rti_setup #(
    parameter int FRAC_BITS = 16
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire rti_pkg::t_ray i_ray,
    rti_stream_if.sink         i_tri,
    rti_stream_if.source       o_geom
);
    localparam int NS = 6;

    logic [NS-1:0] r_vld;
    logic [NS-1:0] adv;

    rti_pkg::t_tri  tri_in;
    rti_pkg::t_tri  r0_tri, r1_tri, r2_tri, r3_tri, r4_tri;
    rti_pkg::t_vec  r0_e1, r0_e2, r2_n, r3_n, r4_n;
    rti_pkg::t_prod r1_p [6];
    rti_pkg::t_prod r3_pd [3];
    rti_pkg::t_prod r3_pv [3];
    rti_pkg::t_prod r3_po [3];
    rti_pkg::t_q    r4_den, r4_dv, r4_do;
    rti_pkg::t_geom r5_geom;
    logic [32:0]    den_abs;

    for (genvar k = 0; k < NS; k++) begin : g_adv
        if (k == NS - 1) begin : g_last
            assign adv[k] = !r_vld[k] || o_geom.ready;
        end else begin : g_mid
            assign adv[k] = !r_vld[k] || adv[k+1];
        end
    end

    assign i_tri.ready  = adv[0];
    assign o_geom.valid = r_vld[NS-1];
    assign o_geom.data  = r5_geom;

    always_comb begin
        tri_in.v0.x = i_tri.data.vertex0_x;
        tri_in.v0.y = i_tri.data.vertex0_y;
        tri_in.v0.z = i_tri.data.vertex0_z;
        tri_in.v1.x = i_tri.data.vertex1_x;
        tri_in.v1.y = i_tri.data.vertex1_y;
        tri_in.v1.z = i_tri.data.vertex1_z;
        tri_in.v2.x = i_tri.data.vertex2_x;
        tri_in.v2.y = i_tri.data.vertex2_y;
        tri_in.v2.z = i_tri.data.vertex2_z;
        den_abs = r4_den[31] ? 33'(-34'(r4_den)) : 33'(r4_den);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (adv[0]) begin
                r_vld[0] <= i_tri.valid;
            end
            for (int k = 1; k < NS; k++) begin
                if (adv[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv[0]) begin
            r0_tri <= tri_in;
            r0_e1  <= rti_pkg::vsub(tri_in.v1, tri_in.v0);
            r0_e2  <= rti_pkg::vsub(tri_in.v2, tri_in.v0);
        end
        if (adv[1]) begin
            r1_tri  <= r0_tri;
            r1_p[0] <= rti_pkg::mul_q(r0_e1.y, r0_e2.z);
            r1_p[1] <= rti_pkg::mul_q(r0_e1.z, r0_e2.y);
            r1_p[2] <= rti_pkg::mul_q(r0_e1.z, r0_e2.x);
            r1_p[3] <= rti_pkg::mul_q(r0_e1.x, r0_e2.z);
            r1_p[4] <= rti_pkg::mul_q(r0_e1.x, r0_e2.y);
            r1_p[5] <= rti_pkg::mul_q(r0_e1.y, r0_e2.x);
        end
        if (adv[2]) begin
            r2_tri <= r1_tri;
            r2_n.x <= rti_pkg::cross_c(r1_p[0], r1_p[1], FRAC_BITS);
            r2_n.y <= rti_pkg::cross_c(r1_p[2], r1_p[3], FRAC_BITS);
            r2_n.z <= rti_pkg::cross_c(r1_p[4], r1_p[5], FRAC_BITS);
        end
        if (adv[3]) begin
            r3_tri   <= r2_tri;
            r3_n     <= r2_n;
            r3_pd[0] <= rti_pkg::mul_q(r2_n.x, i_ray.dir.x);
            r3_pd[1] <= rti_pkg::mul_q(r2_n.y, i_ray.dir.y);
            r3_pd[2] <= rti_pkg::mul_q(r2_n.z, i_ray.dir.z);
            r3_pv[0] <= rti_pkg::mul_q(r2_n.x, r2_tri.v0.x);
            r3_pv[1] <= rti_pkg::mul_q(r2_n.y, r2_tri.v0.y);
            r3_pv[2] <= rti_pkg::mul_q(r2_n.z, r2_tri.v0.z);
            r3_po[0] <= rti_pkg::mul_q(r2_n.x, i_ray.org.x);
            r3_po[1] <= rti_pkg::mul_q(r2_n.y, i_ray.org.y);
            r3_po[2] <= rti_pkg::mul_q(r2_n.z, i_ray.org.z);
        end
        if (adv[4]) begin
            r4_tri <= r3_tri;
            r4_n   <= r3_n;
            r4_den <= rti_pkg::dot3(r3_pd[0], r3_pd[1], r3_pd[2], FRAC_BITS);
            r4_dv  <= rti_pkg::dot3(r3_pv[0], r3_pv[1], r3_pv[2], FRAC_BITS);
            r4_do  <= rti_pkg::dot3(r3_po[0], r3_po[1], r3_po[2], FRAC_BITS);
        end
        if (adv[5]) begin
            r5_geom.vtx <= r4_tri;
            r5_geom.n   <= r4_n;
            r5_geom.num <= 33'(r4_dv) - 33'(r4_do);
            r5_geom.den <= r4_den;
            r5_geom.ok  <= (r4_den != '0) && (den_abs >= 33'(i_ray.eps));
        end
    end

endmodule

`default_nettype wire

@@ rtl/core/rti_divider.sv @@
// ----------------------------------------------------------------------------
// rti_divider
// Pipelined restoring divider for the ray distance, one quotient bit a stage.
// ----------------------------------------------------------------------------
`default_nettype none

module rti_divider #(
    parameter int FRAC_BITS = 16
) (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    rti_stream_if.sink   i_geom,
    rti_stream_if.source o_tval
);
    localparam int QB = 31;
    localparam int NS = QB + 1;

    typedef struct packed {
        rti_pkg::t_tri vtx;
        rti_pkg::t_vec n;
        logic          ok;
        logic          neg;
        logic          ovf;
        logic [63:0]   rem;
        logic [31:0]   dmag;
        logic [QB-1:0] q;
    } t_dstage;

    logic [NS-1:0] r_vld;
    logic [NS-1:0] adv;
    t_dstage       r_st [NS];
    logic [32:0]   nabs;
    logic [31:0]   dabs;
    logic [63:0]   nmag;
    logic          q_neg;

    for (genvar k = 0; k < NS; k++) begin : g_adv
        if (k == NS - 1) begin : g_last
            assign adv[k] = !r_vld[k] || o_tval.ready;
        end else begin : g_mid
            assign adv[k] = !r_vld[k] || adv[k+1];
        end
    end

    assign i_geom.ready = adv[0];
    assign o_tval.valid = r_vld[NS-1];

    always_comb begin
        nabs  = i_geom.data.num[32] ? 33'(-i_geom.data.num) : 33'(i_geom.data.num);
        dabs  = i_geom.data.den[31] ? 32'(-i_geom.data.den) : 32'(i_geom.data.den);
        nmag  = 64'(nabs) << FRAC_BITS;
        q_neg = r_st[NS-1].neg && (r_st[NS-1].ovf || r_st[NS-1].q != '0);
        o_tval.data.vtx = r_st[NS-1].vtx;
        o_tval.data.n   = r_st[NS-1].n;
        o_tval.data.ok  = r_st[NS-1].ok && !q_neg;
        o_tval.data.t   = r_st[NS-1].ovf ? rti_pkg::Q_MAX : {1'b0, r_st[NS-1].q};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (adv[0]) begin
                r_vld[0] <= i_geom.valid;
            end
            for (int k = 1; k < NS; k++) begin
                if (adv[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv[0]) begin
            r_st[0].vtx  <= i_geom.data.vtx;
            r_st[0].n    <= i_geom.data.n;
            r_st[0].ok   <= i_geom.data.ok;
            r_st[0].neg  <= i_geom.data.num[32] ^ i_geom.data.den[31];
            r_st[0].ovf  <= nmag >= (64'(dabs) << QB);
            r_st[0].rem  <= nmag;
            r_st[0].dmag <= dabs;
            r_st[0].q    <= '0;
        end
    end

    for (genvar k = 1; k < NS; k++) begin : g_bit
        localparam int B = QB - k;
        logic [63:0] dsh;
        logic        take;
        t_dstage     n_st;

        assign dsh  = 64'(r_st[k-1].dmag) << B;
        assign take = r_st[k-1].rem >= dsh;

        always_comb begin
            n_st      = r_st[k-1];
            n_st.rem  = take ? r_st[k-1].rem - dsh : r_st[k-1].rem;
            n_st.q[B] = take;
        end

        always_ff @(posedge i_clk) begin
            if (adv[k]) begin
                r_st[k] <= n_st;
            end
        end
    end

endmodule

`default_nettype wire

@@ rtl/core/rti_edge.sv @@
// ----------------------------------------------------------------------------
// rti_edge
// Hit point, the inside-outside test against each triangle edge, and result formatting.
// ----------------------------------------------------------------------------
`default_nettype none

module rti_edge #(
    parameter int FRAC_BITS = 16
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire rti_pkg::t_ray i_ray,
    rti_stream_if.sink         i_tval,
    rti_stream_if.source       o_res
);
    localparam int NS = 7;

    logic [NS-1:0] r_vld;
    logic [NS-1:0] adv;

    rti_pkg::t_tri  r0_tri, r1_tri;
    rti_pkg::t_vec  r0_n, r1_n, r2_n, r3_n, r4_n;
    rti_pkg::t_q    r0_t, r1_t, r2_t, r3_t, r4_t, r5_t;
    logic           r0_ok, r1_ok, r2_ok, r3_ok, r4_ok, r5_ok;
    rti_pkg::t_prod r0_pt [3];
    rti_pkg::t_vec  r1_p;
    rti_pkg::t_vec  r2_ed [3];
    rti_pkg::t_vec  r2_pv [3];
    rti_pkg::t_prod r3_p [3][6];
    rti_pkg::t_vec  r4_c [3];
    rti_pkg::t_prod r5_p [3][3];
    rti_pkg::t_res  r6_res;
    rti_pkg::t_q    e_dot [3];
    logic [2:0]     side_ok;

    for (genvar k = 0; k < NS; k++) begin : g_adv
        if (k == NS - 1) begin : g_last
            assign adv[k] = !r_vld[k] || o_res.ready;
        end else begin : g_mid
            assign adv[k] = !r_vld[k] || adv[k+1];
        end
    end

    assign i_tval.ready = adv[0];
    assign o_res.valid  = r_vld[NS-1];
    assign o_res.data   = r6_res;

    always_comb begin
        for (int e = 0; e < 3; e++) begin
            e_dot[e]   = rti_pkg::dot3(r5_p[e][0], r5_p[e][1], r5_p[e][2], FRAC_BITS);
            side_ok[e] = !e_dot[e][31];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (adv[0]) begin
                r_vld[0] <= i_tval.valid;
            end
            for (int k = 1; k < NS; k++) begin
                if (adv[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv[0]) begin
            r0_tri   <= i_tval.data.vtx;
            r0_n     <= i_tval.data.n;
            r0_t     <= i_tval.data.t;
            r0_ok    <= i_tval.data.ok;
            r0_pt[0] <= rti_pkg::mul_q(i_tval.data.t, i_ray.dir.x);
            r0_pt[1] <= rti_pkg::mul_q(i_tval.data.t, i_ray.dir.y);
            r0_pt[2] <= rti_pkg::mul_q(i_tval.data.t, i_ray.dir.z);
        end
        if (adv[1]) begin
            r1_tri <= r0_tri;
            r1_n   <= r0_n;
            r1_t   <= r0_t;
            r1_ok  <= r0_ok;
            r1_p.x <= rti_pkg::sat_q(rti_pkg::SAT_W'(i_ray.org.x)
                                     + rti_pkg::SAT_W'(r0_pt[0] >>> FRAC_BITS));
            r1_p.y <= rti_pkg::sat_q(rti_pkg::SAT_W'(i_ray.org.y)
                                     + rti_pkg::SAT_W'(r0_pt[1] >>> FRAC_BITS));
            r1_p.z <= rti_pkg::sat_q(rti_pkg::SAT_W'(i_ray.org.z)
                                     + rti_pkg::SAT_W'(r0_pt[2] >>> FRAC_BITS));
        end
        if (adv[2]) begin
            r2_n     <= r1_n;
            r2_t     <= r1_t;
            r2_ok    <= r1_ok;
            r2_ed[0] <= rti_pkg::vsub(r1_tri.v1, r1_tri.v0);
            r2_ed[1] <= rti_pkg::vsub(r1_tri.v2, r1_tri.v1);
            r2_ed[2] <= rti_pkg::vsub(r1_tri.v0, r1_tri.v2);
            r2_pv[0] <= rti_pkg::vsub(r1_p, r1_tri.v0);
            r2_pv[1] <= rti_pkg::vsub(r1_p, r1_tri.v1);
            r2_pv[2] <= rti_pkg::vsub(r1_p, r1_tri.v2);
        end
        if (adv[3]) begin
            r3_n  <= r2_n;
            r3_t  <= r2_t;
            r3_ok <= r2_ok;
            for (int e = 0; e < 3; e++) begin
                r3_p[e][0] <= rti_pkg::mul_q(r2_ed[e].y, r2_pv[e].z);
                r3_p[e][1] <= rti_pkg::mul_q(r2_ed[e].z, r2_pv[e].y);
                r3_p[e][2] <= rti_pkg::mul_q(r2_ed[e].z, r2_pv[e].x);
                r3_p[e][3] <= rti_pkg::mul_q(r2_ed[e].x, r2_pv[e].z);
                r3_p[e][4] <= rti_pkg::mul_q(r2_ed[e].x, r2_pv[e].y);
                r3_p[e][5] <= rti_pkg::mul_q(r2_ed[e].y, r2_pv[e].x);
            end
        end
        if (adv[4]) begin
            r4_n  <= r3_n;
            r4_t  <= r3_t;
            r4_ok <= r3_ok;
            for (int e = 0; e < 3; e++) begin
                r4_c[e].x <= rti_pkg::cross_c(r3_p[e][0], r3_p[e][1], FRAC_BITS);
                r4_c[e].y <= rti_pkg::cross_c(r3_p[e][2], r3_p[e][3], FRAC_BITS);
                r4_c[e].z <= rti_pkg::cross_c(r3_p[e][4], r3_p[e][5], FRAC_BITS);
            end
        end
        if (adv[5]) begin
            r5_t  <= r4_t;
            r5_ok <= r4_ok;
            for (int e = 0; e < 3; e++) begin
                r5_p[e][0] <= rti_pkg::mul_q(r4_n.x, r4_c[e].x);
                r5_p[e][1] <= rti_pkg::mul_q(r4_n.y, r4_c[e].y);
                r5_p[e][2] <= rti_pkg::mul_q(r4_n.z, r4_c[e].z);
            end
        end
        if (adv[6]) begin
            r6_res.hit      <= r5_ok && (&side_ok);
            r6_res.distance <= (r5_ok && (&side_ok)) ? r5_t : '0;
        end
    end

endmodule

`default_nettype wire

@@ rtl/core/ray_triangle_intersection_top.sv @@
// ----------------------------------------------------------------------------
// ray_triangle_intersection_top
// Streaming ray/triangle intersection in signed fixed point.
//
// One triangle (nine vertex coordinates) enters per transaction on i_tri and
// one result (hit flag and distance) leaves per transaction on o_res, in
// order. Ray origin, direction and parallel epsilon are written through the
// plain write port (i_cfg_we, i_cfg_idx, i_cfg_data) by the user while the
// block is idle; the block does not enforce this. Unused indexes are ignored.
// Throughput is one triangle per cycle unless o_res stalls. An accepted
// triangle passes 6 stages of normal and plane setup, 32 stages of the
// bit-per-stage distance divider, 7 stages of hit point and edge tests.
// Reset clears all stage valid bits and loads the register reset values
// (zero ray, epsilon 7). When the receiver stalls, results back up stage by
// stage; empty stages keep filling, so i_tri.ready falls only once the
// whole pipeline holds data.
// ----------------------------------------------------------------------------
`default_nettype none

module ray_triangle_intersection_top #(
    parameter int FRAC_BITS = 16
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [2:0]  i_cfg_idx,
    input  wire logic [31:0] i_cfg_data,
    rti_stream_if.sink       i_tri,
    rti_stream_if.source     o_res
);
    rti_pkg::t_ray r_ray;

    rti_stream_if #(.t_data(rti_pkg::t_geom)) s_geom ();
    rti_stream_if #(.t_data(rti_pkg::t_tval)) s_tval ();

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ray.org <= '0;
            r_ray.dir <= '0;
            r_ray.eps <= 16'd7;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                rti_pkg::CFG_ORG_X: r_ray.org.x <= i_cfg_data;
                rti_pkg::CFG_ORG_Y: r_ray.org.y <= i_cfg_data;
                rti_pkg::CFG_ORG_Z: r_ray.org.z <= i_cfg_data;
                rti_pkg::CFG_DIR_X: r_ray.dir.x <= i_cfg_data;
                rti_pkg::CFG_DIR_Y: r_ray.dir.y <= i_cfg_data;
                rti_pkg::CFG_DIR_Z: r_ray.dir.z <= i_cfg_data;
                rti_pkg::CFG_EPS:   r_ray.eps   <= i_cfg_data[15:0];
                default: begin
                end
            endcase
        end
    end

    rti_setup #(.FRAC_BITS(FRAC_BITS)) u_setup (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ray   (r_ray),
        .i_tri   (i_tri),
        .o_geom  (s_geom)
    );

    rti_divider #(.FRAC_BITS(FRAC_BITS)) u_divider (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_geom  (s_geom),
        .o_tval  (s_tval)
    );

    rti_edge #(.FRAC_BITS(FRAC_BITS)) u_edge (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ray   (r_ray),
        .i_tval  (s_tval),
        .o_res   (o_res)
    );

endmodule

`default_nettype wire

@@ dv/ray_triangle_intersection_checker.sv @@
// ----------------------------------------------------------------------------
// ray_triangle_intersection_checker
// Watches the triangle and result channels and the register write port,
// predicts each hit flag and distance, and compares results in order.
// ----------------------------------------------------------------------------
`default_nettype none

module ray_triangle_intersection_checker (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [2:0]  i_cfg_idx,
    input  wire logic [31:0] i_cfg_data,
    rti_stream_if            tri_ch,
    rti_stream_if            res_ch,
    output int               o_errors,
    output int               o_pending,
    output int               o_hits
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int FB = 16;

    typedef struct {
        longint x;
        longint y;
        longint z;
    } t_v64;

    t_v64          ray_org;
    t_v64          ray_dir;
    longint        ray_eps;
    rti_pkg::t_res hit_queue[$];

    function automatic longint clamp32(input longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    function automatic longint floor_q(input longint v);
        return v >>> FB;
    endfunction

    function automatic t_v64 diff3(input t_v64 a, input t_v64 b);
        t_v64 r;
        r.x = clamp32(a.x - b.x);
        r.y = clamp32(a.y - b.y);
        r.z = clamp32(a.z - b.z);
        return r;
    endfunction

    function automatic t_v64 cross3(input t_v64 a, input t_v64 b);
        t_v64 r;
        r.x = clamp32(floor_q(a.y * b.z - a.z * b.y));
        r.y = clamp32(floor_q(a.z * b.x - a.x * b.z));
        r.z = clamp32(floor_q(a.x * b.y - a.y * b.x));
        return r;
    endfunction

    function automatic longint dot_q(input t_v64 a, input t_v64 b);
        return clamp32(floor_q(a.x * b.x) + floor_q(a.y * b.y) + floor_q(a.z * b.z));
    endfunction

    function automatic bit edge_inside(input t_v64 n, input t_v64 va, input t_v64 vb,
                                       input t_v64 p);
        return dot_q(n, cross3(diff3(vb, va), diff3(p, va))) >= 0;
    endfunction

    function automatic rti_pkg::t_res predict(input rti_pkg::t_tri_in tr);
        t_v64          v0, v1, v2, n, p;
        longint        den, aden, num, q, t;
        rti_pkg::t_res r;
        v0.x = tr.vertex0_x; v0.y = tr.vertex0_y; v0.z = tr.vertex0_z;
        v1.x = tr.vertex1_x; v1.y = tr.vertex1_y; v1.z = tr.vertex1_z;
        v2.x = tr.vertex2_x; v2.y = tr.vertex2_y; v2.z = tr.vertex2_z;
        r.hit = 1'b0;
        r.distance = '0;
        n = cross3(diff3(v1, v0), diff3(v2, v0));
        den = dot_q(n, ray_dir);
        aden = den < 0 ? -den : den;
        if (den != 0 && aden >= ray_eps) begin
            num = dot_q(n, v0) - dot_q(n, ray_org);
            q = (num * (64'sd1 <<< FB)) / den;
            if (q >= 0) begin
                t = clamp32(q);
                p.x = clamp32(ray_org.x + floor_q(t * ray_dir.x));
                p.y = clamp32(ray_org.y + floor_q(t * ray_dir.y));
                p.z = clamp32(ray_org.z + floor_q(t * ray_dir.z));
                if (edge_inside(n, v0, v1, p) && edge_inside(n, v1, v2, p)
                        && edge_inside(n, v2, v0, p)) begin
                    r.hit = 1'b1;
                    r.distance = rti_pkg::t_q'(t);
                end
            end
        end
        return r;
    endfunction

    assign o_pending = hit_queue.size();

    always @(posedge i_clk) begin
        rti_pkg::t_res exp_res;
        rti_pkg::t_res got;
        if (!i_rst_n) begin
            ray_org = '{0, 0, 0};
            ray_dir = '{0, 0, 0};
            ray_eps = 7;
            hit_queue.delete();
            o_errors <= 0;
            o_hits <= 0;
        end else begin
            if (i_cfg_we) begin
                case (rti_pkg::t_cfg_idx'(i_cfg_idx))
                    rti_pkg::CFG_ORG_X: ray_org.x = rti_pkg::t_q'(i_cfg_data);
                    rti_pkg::CFG_ORG_Y: ray_org.y = rti_pkg::t_q'(i_cfg_data);
                    rti_pkg::CFG_ORG_Z: ray_org.z = rti_pkg::t_q'(i_cfg_data);
                    rti_pkg::CFG_DIR_X: ray_dir.x = rti_pkg::t_q'(i_cfg_data);
                    rti_pkg::CFG_DIR_Y: ray_dir.y = rti_pkg::t_q'(i_cfg_data);
                    rti_pkg::CFG_DIR_Z: ray_dir.z = rti_pkg::t_q'(i_cfg_data);
                    rti_pkg::CFG_EPS:   ray_eps = i_cfg_data[15:0];
                    default: ;
                endcase
            end
            if (res_ch.valid && res_ch.ready) begin
                got = res_ch.data;
                if (hit_queue.size() == 0) begin
                    $error("result transaction with nothing expected");
                    o_errors <= o_errors + 1;
                end else begin
                    exp_res = hit_queue.pop_front();
                    if (got.hit !== exp_res.hit) begin
                        $error("hit: expected %0d, actual %0d", exp_res.hit, got.hit);
                        o_errors <= o_errors + 1;
                    end else if (got.distance !== exp_res.distance) begin
                        $error("distance: expected %0d, actual %0d",
                               exp_res.distance, got.distance);
                        o_errors <= o_errors + 1;
                    end
                    if (exp_res.hit) o_hits <= o_hits + 1;
                end
            end
            if (tri_ch.valid && tri_ch.ready) hit_queue.push_back(predict(tri_ch.data));
        end
    end
endmodule

`default_nettype wire

@@ dv/ray_triangle_intersection_top_tb.sv @@
// ----------------------------------------------------------------------------
// ray_triangle_intersection_top_tb
// Streams directed and random triangles through the intersection pipeline
// under several ray settings, with random stalls on both channels and one
// long receiver hold-off; the checker predicts and compares every result.
// ----------------------------------------------------------------------------
`default_nettype none

module ray_triangle_intersection_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic [2:0]  i_cfg_idx = '0;
    logic [31:0] i_cfg_data = '0;
    int          errors, pending, hits;
    int          sent = 0;
    bit          calm = 1'b0;
    bit          hold = 1'b0;

    rti_stream_if #(.t_data(rti_pkg::t_tri_in)) tri_ch ();
    rti_stream_if #(.t_data(rti_pkg::t_res))    res_ch ();

    ray_triangle_intersection_top dut (
        .i_clk, .i_rst_n, .i_cfg_we, .i_cfg_idx, .i_cfg_data,
        .i_tri(tri_ch), .o_res(res_ch)
    );

    ray_triangle_intersection_checker u_checker (
        .i_clk, .i_rst_n, .i_cfg_we, .i_cfg_idx, .i_cfg_data,
        .tri_ch, .res_ch, .o_errors(errors), .o_pending(pending), .o_hits(hits)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    initial begin
        tri_ch.valid = 1'b0;
        tri_ch.data = '0;
        res_ch.ready = 1'b0;
    end

    // receiver: random stalls, one long hold-off
    always @(posedge i_clk) begin
        if (!i_rst_n) res_ch.ready <= 1'b0;
        else res_ch.ready <= !hold && (calm || $urandom_range(99) >= 18);
    end

    initial begin
        wait (sent > 300);
        @(posedge i_clk);
        hold <= 1'b1;
        repeat (200) @(posedge i_clk);
        hold <= 1'b0;
    end

    function automatic rti_pkg::t_q rnd_coord(input int mode);
        case (mode)
            0: return rti_pkg::t_q'($urandom);
            1: return rti_pkg::t_q'($signed($urandom_range(8 << 16)) - (4 << 16));
            default: return rti_pkg::t_q'($signed($urandom_range(512)) - 256);
        endcase
    endfunction

    task automatic write_reg(input rti_pkg::t_cfg_idx idx, input logic [31:0] val);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
    endtask

    task automatic set_ray(input rti_pkg::t_q ox, oy, oz, dx, dy, dz,
                           input logic [15:0] eps);
        write_reg(rti_pkg::CFG_ORG_X, ox);
        write_reg(rti_pkg::CFG_ORG_Y, oy);
        write_reg(rti_pkg::CFG_ORG_Z, oz);
        write_reg(rti_pkg::CFG_DIR_X, dx);
        write_reg(rti_pkg::CFG_DIR_Y, dy);
        write_reg(rti_pkg::CFG_DIR_Z, dz);
        write_reg(rti_pkg::CFG_EPS, 32'(eps));
        // unused index, must be ignored
        i_cfg_we <= 1'b1;
        i_cfg_idx <= 3'd7;
        i_cfg_data <= $urandom;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic send_tri(input rti_pkg::t_tri_in tr);
        if (!calm) begin
            while ($urandom_range(99) < 18) begin
                tri_ch.valid <= 1'b0;
                @(posedge i_clk);
            end
        end
        tri_ch.valid <= 1'b1;
        tri_ch.data <= tr;
        @(posedge i_clk);
        while (!tri_ch.ready) @(posedge i_clk);
        sent++;
    endtask

    task automatic drain();
        int n;
        n = 0;
        tri_ch.valid <= 1'b0;
        while (pending != 0 && n < 20000) begin
            @(posedge i_clk);
            n++;
        end
        repeat (60) @(posedge i_clk);
    endtask

    function automatic rti_pkg::t_tri_in around(input int mode);
        rti_pkg::t_tri_in tr;
        tr.vertex0_x = rnd_coord(mode); tr.vertex0_y = rnd_coord(mode);
        tr.vertex0_z = rnd_coord(mode); tr.vertex1_x = rnd_coord(mode);
        tr.vertex1_y = rnd_coord(mode); tr.vertex1_z = rnd_coord(mode);
        tr.vertex2_x = rnd_coord(mode); tr.vertex2_y = rnd_coord(mode);
        tr.vertex2_z = rnd_coord(mode);
        return tr;
    endfunction

    initial begin
        rti_pkg::t_tri_in tr;
        int               mode;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // zero ray at reset: every triangle is a parallel miss
        tr = '{default: 32'sh10000};
        send_tri(tr);
        tr = around(0);
        send_tri(tr);
        drain();

        set_ray(0, 0, -(5 << 16), 0, 0, 1 << 16, 16'd7);
        // triangle in z=0 facing the ray, both windings, and a miss to one side
        send_tri('{-(1 << 16), -(1 << 16), 0, 1 << 16, -(1 << 16), 0, 0, 1 << 16, 0});
        send_tri('{-(1 << 16), -(1 << 16), 0, 0, 1 << 16, 0, 1 << 16, -(1 << 16), 0});
        send_tri('{3 << 16, 3 << 16, 0, 5 << 16, 3 << 16, 0, 4 << 16, 5 << 16, 0});
        // behind the origin
        send_tri('{-(1 << 16), -(1 << 16), -(9 << 16), 1 << 16, -(1 << 16),
                   -(9 << 16), 0, 1 << 16, -(9 << 16)});
        // plane containing the ray: zero denominator
        send_tri('{0, 0, 0, 0, 0, 1 << 16, 1 << 16, 0, 0});
        // degenerate triangle
        send_tri('{default: 32'sh0});
        // extremes of the coordinate range
        send_tri('{rti_pkg::Q_MAX, rti_pkg::Q_MIN, rti_pkg::Q_MAX, rti_pkg::Q_MIN,
                   rti_pkg::Q_MAX, rti_pkg::Q_MIN, rti_pkg::Q_MAX, rti_pkg::Q_MAX,
                   rti_pkg::Q_MIN});
        send_tri('{rti_pkg::Q_MIN, rti_pkg::Q_MIN, 0, rti_pkg::Q_MAX, rti_pkg::Q_MIN, 0,
                   0, rti_pkg::Q_MAX, 0});
        send_tri('{default: -32'sd1});
        drain();

        // epsilon 0 and largest, near-parallel direction, extreme origin
        set_ray(rti_pkg::Q_MAX, rti_pkg::Q_MIN, 0, 1, 0, 1, 16'd0);
        send_tri('{0, 0, 0, 1 << 16, 0, 0, 0, 1 << 16, 0});
        send_tri('{rti_pkg::Q_MIN, rti_pkg::Q_MAX, 0, rti_pkg::Q_MAX, rti_pkg::Q_MAX, 0,
                   rti_pkg::Q_MAX, rti_pkg::Q_MIN, 0});
        drain();
        set_ray(rti_pkg::Q_MIN, rti_pkg::Q_MAX, rti_pkg::Q_MIN, rti_pkg::Q_MAX,
                rti_pkg::Q_MIN, rti_pkg::Q_MAX, 16'hFFFF);
        send_tri(around(0));
        send_tri('{0, 0, 0, 1 << 16, 0, 0, 0, 1 << 16, 0});
        drain();

        for (int ph = 0; ph < 6; ph++) begin
            calm = (ph == 2);
            case (ph)
                0: set_ray(0, 0, 0, 1 << 16, 1 << 15, 1 << 14, 16'd7);
                1: set_ray(rti_pkg::t_q'($urandom), rti_pkg::t_q'($urandom),
                           rti_pkg::t_q'($urandom), rti_pkg::t_q'($urandom),
                           rti_pkg::t_q'($urandom), rti_pkg::t_q'($urandom),
                           16'($urandom));
                2: set_ray(-(2 << 16), 1 << 14, 1 << 16, 3 << 16, -(1 << 15),
                           -(1 << 16), 16'd100);
                3: set_ray(rti_pkg::t_q'($signed($urandom_range(1 << 18)) - (1 << 17)),
                           rti_pkg::t_q'($signed($urandom_range(1 << 18)) - (1 << 17)),
                           rti_pkg::t_q'($signed($urandom_range(1 << 18)) - (1 << 17)),
                           rti_pkg::t_q'($signed($urandom_range(1 << 17)) - (1 << 16)),
                           rti_pkg::t_q'($signed($urandom_range(1 << 17)) - (1 << 16)),
                           rti_pkg::t_q'($signed($urandom_range(1 << 17)) - (1 << 16)),
                           16'd7);
                4: set_ray(0, 0, 0, 1, -1, 1, 16'd1);
                default: set_ray(0, 0, 0, 0, 0, 1 << 16, 16'd0);
            endcase
            for (int i = 0; i < 250; i++) begin
                mode = $urandom_range(9) < 2 ? 0 : ($urandom_range(9) < 7 ? 1 : 2);
                tr = around(mode);
                // half of the mode 1 and 2 triangles straddle the ray axis so hits occur
                if (mode != 0 && $urandom_range(1)) begin
                    tr.vertex0_x = -(tr.vertex0_x & 32'sh7FFFFFFF) >>> 1;
                    tr.vertex1_x = (tr.vertex1_x & 32'sh7FFFFFFF) >>> 1;
                    tr.vertex2_y = (tr.vertex2_y & 32'sh7FFFFFFF) >>> 1;
                    tr.vertex0_y = -(tr.vertex0_y & 32'sh7FFFFFFF) >>> 2;
                    tr.vertex1_y = -(tr.vertex1_y & 32'sh7FFFFFFF) >>> 2;
                end
                send_tri(tr);
            end
            drain();
        end

        $display("covered %0d triangles over several ray settings, %0d hits",
                 sent, hits);
        if (errors == 0 && pending == 0) begin
            $display("ray_triangle_intersection_top_tb: done, clean");
        end else begin
            $display("ray_triangle_intersection_top_tb: done, errors");
        end
        $finish;
    end

    initial begin
        #5ms;
        $display("ray_triangle_intersection_top_tb: done, errors");
        $finish;
    end
endmodule

`default_nettype wire
